>>> rtl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants of the keypad calculator
// Key kinds, pending operator codes, micro-op and sequencing codes, the
// control word type and the microprogram ROM with its dispatch decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kcc_pkg;

	// Key kinds on req_type
	localparam logic [2:0] KIND_DIGIT = 3'd0;
	localparam logic [2:0] KIND_OPER  = 3'd1;
	localparam logic [2:0] KIND_EQUAL = 3'd2;
	localparam logic [2:0] KIND_CLEAR = 3'd3;
	localparam logic [2:0] KIND_BACK  = 3'd4;

	localparam logic [3:0] DIGIT_MAX   = 4'd9;
	localparam logic [3:0] KEY_OP_MAX  = 4'd3;
	localparam logic [31:0] DEC_BASE   = 32'd10;

	// ceil(2^35 / 10): magnitude times this, shifted right by 35, is magnitude / 10
	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;

	// Pending operator codes
	localparam logic [2:0] PEND_NONE = 3'd0;
	localparam logic [2:0] PEND_ADD  = 3'd1;
	localparam logic [2:0] PEND_SUB  = 3'd2;
	localparam logic [2:0] PEND_MUL  = 3'd3;
	localparam logic [2:0] PEND_DIV  = 3'd4;

	// Micro-ops
	localparam logic [3:0] UOP_NOP     = 4'd0;
	localparam logic [3:0] UOP_DIGIT   = 4'd1;
	localparam logic [3:0] UOP_OPLATCH = 4'd2;
	localparam logic [3:0] UOP_ADD     = 4'd3;
	localparam logic [3:0] UOP_SUB     = 4'd4;
	localparam logic [3:0] UOP_MUL     = 4'd5;
	localparam logic [3:0] UOP_ZEROEQ  = 4'd6;
	localparam logic [3:0] UOP_CLEAR   = 4'd7;
	localparam logic [3:0] UOP_DLDEQ   = 4'd8;
	localparam logic [3:0] UOP_BKMUL   = 4'd9;
	localparam logic [3:0] UOP_DSTEP   = 4'd10;
	localparam logic [3:0] UOP_DFIN    = 4'd11;
	localparam logic [3:0] UOP_BKFIN   = 4'd12;

	// Sequencing codes
	localparam logic [2:0] SEQ_NEXT = 3'd0;
	localparam logic [2:0] SEQ_JUMP = 3'd1;
	localparam logic [2:0] SEQ_LOOP = 3'd2;
	localparam logic [2:0] SEQ_ZJMP = 3'd3;
	localparam logic [2:0] SEQ_END  = 3'd4;

	// Microprogram addresses
	localparam logic [3:0] A_NOP   = 4'd0;
	localparam logic [3:0] A_DIGIT = 4'd1;
	localparam logic [3:0] A_OPL   = 4'd2;
	localparam logic [3:0] A_ADD   = 4'd3;
	localparam logic [3:0] A_SUB   = 4'd4;
	localparam logic [3:0] A_MUL   = 4'd5;
	localparam logic [3:0] A_EQZ   = 4'd6;
	localparam logic [3:0] A_CLR   = 4'd7;
	localparam logic [3:0] A_DIVE  = 4'd8;
	localparam logic [3:0] A_DSTEP = 4'd9;
	localparam logic [3:0] A_DFIN  = 4'd10;
	localparam logic [3:0] A_BACK  = 4'd11;
	localparam logic [3:0] A_BKFIN = 4'd12;
	localparam logic [3:0] A_LAST  = 4'd12;

	localparam logic [4:0] DIV_STEPS_M1 = 5'd31;

	typedef struct packed {
		logic [3:0] uop;
		logic [2:0] seq;
		logic [3:0] target;
	} cw_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	function automatic cw_t ucode(input logic [3:0] addr);
		cw_t cw;
		cw = '{uop: UOP_NOP, seq: SEQ_END, target: A_NOP};
		unique case (addr)
			A_NOP:   cw = '{uop: UOP_NOP,     seq: SEQ_END,  target: A_NOP};
			A_DIGIT: cw = '{uop: UOP_DIGIT,   seq: SEQ_END,  target: A_NOP};
			A_OPL:   cw = '{uop: UOP_OPLATCH, seq: SEQ_END,  target: A_NOP};
			A_ADD:   cw = '{uop: UOP_ADD,     seq: SEQ_END,  target: A_NOP};
			A_SUB:   cw = '{uop: UOP_SUB,     seq: SEQ_END,  target: A_NOP};
			A_MUL:   cw = '{uop: UOP_MUL,     seq: SEQ_END,  target: A_NOP};
			A_EQZ:   cw = '{uop: UOP_ZEROEQ,  seq: SEQ_END,  target: A_NOP};
			A_CLR:   cw = '{uop: UOP_CLEAR,   seq: SEQ_END,  target: A_NOP};
			A_DIVE:  cw = '{uop: UOP_DLDEQ,   seq: SEQ_ZJMP, target: A_EQZ};
			A_DSTEP: cw = '{uop: UOP_DSTEP,   seq: SEQ_LOOP, target: A_DSTEP};
			A_DFIN:  cw = '{uop: UOP_DFIN,    seq: SEQ_END,  target: A_NOP};
			A_BACK:  cw = '{uop: UOP_BKMUL,   seq: SEQ_NEXT, target: A_NOP};
			A_BKFIN: cw = '{uop: UOP_BKFIN,   seq: SEQ_END,  target: A_NOP};
			default: cw = '{uop: UOP_NOP,     seq: SEQ_END,  target: A_NOP};
		endcase
		return cw;
	endfunction

	// Entry point of the microprogram for one key
	function automatic logic [3:0] dispatch(
		input logic [2:0] kind,
		input logic [3:0] key,
		input logic [2:0] pend,
		input logic       flag
	);
		logic [3:0] addr;
		addr = A_NOP;
		unique case (kind)
			KIND_DIGIT: addr = (key <= DIGIT_MAX) ? A_DIGIT : A_NOP;
			KIND_OPER:  addr = (key <= KEY_OP_MAX && !flag) ? A_OPL : A_NOP;
			KIND_EQUAL: begin
				case (pend)
					PEND_ADD: addr = A_ADD;
					PEND_SUB: addr = A_SUB;
					PEND_MUL: addr = A_MUL;
					PEND_DIV: addr = A_DIVE;
					default:  addr = A_EQZ;
				endcase
			end
			KIND_CLEAR: addr = A_CLR;
			KIND_BACK:  addr = A_BACK;
			default:    addr = A_NOP;
		endcase
		return addr;
	endfunction

endpackage

`default_nettype wire

>>> rtl/kcc_divider.sv
// ----------------------------------------------------------------------------
// kcc_divider: radix-2 restoring signed divider
// Load takes magnitudes of both operands; each step retires one quotient bit.
// The result is the truncated signed quotient after 32 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module kcc_divider (
	input  wire logic              clk,
	input  wire kcc_pkg::div_ctrl_t ctrl,
	input  wire logic [31:0]       dividend,
	input  wire logic [31:0]       divisor,
	output logic [31:0]            quotient
);

	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] shifted;
	logic [32:0] trial;

	function automatic logic [31:0] mag(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= mag(dividend);
			dvs_q <= mag(divisor);
			rem_q <= '0;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (ctrl.step) begin
			// keep the shifted remainder when the trial goes negative
			if (trial[32]) begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end
		end
	end

	assign quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

`default_nettype wire

>>> rtl/keypad_calculator_controller.sv
// ----------------------------------------------------------------------------
// keypad_calculator_controller: four-function integer keypad calculator
// Microcoded controller: a dispatch decoder picks a routine, a ROM of control
// words drives the display/operand datapath and an iterative divider.
// ----------------------------------------------------------------------------
// Routines: digit, operator, clear and the add/sub/mul/no-operator equals
//   run one control word; backspace runs a reciprocal multiply, then a sign
//   fix; divide-equals runs load, 32 divider steps, then finish. Divide by
//   zero goes from the load straight to the zeroing word.
// Throughput: one item at a time; next item accepted the cycle after the
//   result is registered. The final step waits while an earlier result is
//   still held by out_stall.
// Reset: arst_n clears display, operand, pending operator, flag and sequencer.
`default_nettype none

module keypad_calculator_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [3:0]  key_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [31:0] display_value
);

	// Architectural state
	logic [31:0] shown_q;
	logic [31:0] first_q;
	logic [2:0]  pend_q;
	logic        flag_q;

	// Sequencer
	logic        busy_q;
	logic [3:0]  upc_q;
	logic [4:0]  cnt_q;
	logic [3:0]  key_q;

	// Backspace quotient magnitude
	logic [31:0] bk_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] disp_q;

	kcc_pkg::cw_t      cw;
	kcc_pkg::div_ctrl_t div_ctrl;
	logic        in_acc;
	logic        out_acc;
	logic        step_en;
	logic [31:0] shown_nx;
	logic        flag_nx;
	logic [31:0] div_q;
	logic [31:0] prod;
	logic [31:0] bk_mag;
	logic [63:0] bk_prod;

	assign cw = kcc_pkg::ucode(upc_q);

	// Accept only while the sequencer is parked
	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_acc  = out_valid_q && !out_stall;

	// Hold the final step while the previous result is still waiting
	assign step_en = busy_q &&
		!(cw.seq == kcc_pkg::SEQ_END && out_valid_q && out_stall);

	// Divider: equals divides the first operand by the display
	assign div_ctrl = '{
		load: step_en && cw.uop == kcc_pkg::UOP_DLDEQ,
		step: step_en && cw.uop == kcc_pkg::UOP_DSTEP
	};

	kcc_divider u_div (
		.clk      (clk),
		.ctrl     (div_ctrl),
		.dividend (first_q),
		.divisor  (shown_q),
		.quotient (div_q)
	);

	assign prod = first_q * shown_q;

	// Backspace: divide the display magnitude by ten with a reciprocal multiply
	assign bk_mag  = shown_q[31] ? (32'd0 - shown_q) : shown_q;
	assign bk_prod = {32'd0, bk_mag} * {32'd0, kcc_pkg::RECIP10};

	always_ff @(posedge clk) begin
		if (step_en && cw.uop == kcc_pkg::UOP_BKMUL) begin
			bk_q <= {3'd0, bk_prod[63:35]};
		end
	end

	// Datapath for the current micro-op
	always_comb begin
		shown_nx = shown_q;
		flag_nx  = flag_q;
		unique case (cw.uop)
			kcc_pkg::UOP_DIGIT: begin
				if (flag_q) begin
					shown_nx = {28'd0, key_q};
					flag_nx  = 1'b0;
				end else begin
					// times ten as (x << 3) + (x << 1), wrapping
					shown_nx = {shown_q[28:0], 3'b000} + {shown_q[30:0], 1'b0}
						+ {28'd0, key_q};
				end
			end
			kcc_pkg::UOP_OPLATCH: flag_nx = 1'b1;
			kcc_pkg::UOP_ADD: begin
				shown_nx = first_q + shown_q;
				flag_nx  = 1'b1;
			end
			kcc_pkg::UOP_SUB: begin
				shown_nx = first_q - shown_q;
				flag_nx  = 1'b1;
			end
			kcc_pkg::UOP_MUL: begin
				shown_nx = prod;
				flag_nx  = 1'b1;
			end
			kcc_pkg::UOP_ZEROEQ: begin
				shown_nx = '0;
				flag_nx  = 1'b1;
			end
			kcc_pkg::UOP_CLEAR: shown_nx = '0;
			kcc_pkg::UOP_DFIN: begin
				shown_nx = div_q;
				flag_nx  = 1'b1;
			end
			// truncate toward zero: restore the sign of the display
			kcc_pkg::UOP_BKFIN: shown_nx = shown_q[31] ? (32'd0 - bk_q) : bk_q;
			default: begin
				shown_nx = shown_q;
				flag_nx  = flag_q;
			end
		endcase
	end

	// Sequencer: dispatch on accept, then walk the control words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			upc_q    <= kcc_pkg::A_NOP;
			cnt_q    <= '0;
			shown_q  <= '0;
			first_q  <= '0;
			pend_q   <= kcc_pkg::PEND_NONE;
			flag_q   <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			upc_q  <= kcc_pkg::dispatch(req_type, key_value, pend_q, flag_q);
		end else if (step_en) begin
			shown_q <= shown_nx;
			flag_q  <= flag_nx;
			if (cw.uop == kcc_pkg::UOP_OPLATCH) begin
				first_q <= shown_q;
				pend_q  <= key_q[2:0] + 3'd1;
			end
			if (cw.uop == kcc_pkg::UOP_DLDEQ) begin
				cnt_q <= kcc_pkg::DIV_STEPS_M1;
			end
			if (cw.uop == kcc_pkg::UOP_DSTEP) begin
				cnt_q <= cnt_q - 5'd1;
			end
			unique case (cw.seq)
				kcc_pkg::SEQ_NEXT: upc_q <= upc_q + 4'd1;
				kcc_pkg::SEQ_JUMP: upc_q <= cw.target;
				kcc_pkg::SEQ_LOOP: upc_q <= (cnt_q != '0) ? cw.target : upc_q + 4'd1;
				kcc_pkg::SEQ_ZJMP: upc_q <= (shown_q == '0) ? cw.target : upc_q + 4'd1;
				kcc_pkg::SEQ_END:  busy_q <= 1'b0;
				default:           busy_q <= 1'b0;
			endcase
		end
	end

	// Key value is needed only by the digit and operator routines
	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= key_value;
		end
	end

	// Result register: load on the final step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && cw.seq == kcc_pkg::SEQ_END) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && cw.seq == kcc_pkg::SEQ_END) begin
			disp_q <= shown_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign display_value = disp_q;

	// The program counter stays inside the microprogram
	a_upc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> upc_q <= kcc_pkg::A_LAST)
		else $error("micro-PC left the program");

	// A new result only appears after a sequencer step
	a_out_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q))
		else $error("result without a finishing step");

	// An accepted item starts the sequencer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q)
		else $error("accepted item did not start the sequencer");

	// The divide loop counter only runs inside the divide step
	a_cnt_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != '0 && upc_q != kcc_pkg::A_DSTEP) |->
		(upc_q == kcc_pkg::A_DIVE || upc_q == kcc_pkg::A_BACK
			|| upc_q == kcc_pkg::A_EQZ || upc_q == kcc_pkg::A_DFIN
			|| !$past(busy_q) || $past(upc_q) != kcc_pkg::A_DSTEP))
		else $error("divide loop left early");

endmodule

`default_nettype wire
